// ===== rtl/tmpsp_pkg.sv =====
`timescale 1ns / 1ps
package tmpsp_pkg;
  localparam int unsigned HeapDepthDefault = 256;
  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 31;
  localparam int unsigned KeptW = 9;
  localparam int unsigned PenW = 31;
  localparam int unsigned SumW = 39;
  localparam int unsigned PosW = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgMaxKept = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPenalty = 1'b1;
endpackage

// ===== rtl/tmpsp_heap.sv =====
`timescale 1ns / 1ps
// heap memory with sift-up / sift-down sequencer
module tmpsp_heap import tmpsp_pkg::*; #(
  parameter int unsigned HeapDepth = HeapDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          insert_i,   // 1 insert at count, 0 replace root
  input  logic [EntryW-1:0]             val_i,
  input  logic [$clog2(HeapDepth+1)-1:0] count_i,  // size after insert / current size
  output logic                          done_o,
  output logic [EntryW-1:0]             root_o      // copy of the root entry
);
  localparam int unsigned AW = $clog2(HeapDepth);
  localparam int unsigned CW = $clog2(HeapDepth+1);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_WAIT, S_DN_CMP, S_DONE
  } state_e;

  logic [EntryW-1:0] mem [HeapDepth];
  state_e            state_q;
  logic [CW:0]       at_q;      // wide enough for 2*at+2
  logic [CW-1:0]     n_q;
  logic [EntryW-1:0] v_q;
  logic [EntryW-1:0] rd_a_q, rd_b_q;
  logic [CW:0]       l_w, r_w, p_w;
  logic              r_ok_q;
  logic [EntryW-1:0] root_q;

  assign l_w = (at_q << 1) + (CW+1)'(1);
  assign r_w = l_w + (CW+1)'(1);
  assign p_w = (at_q - (CW+1)'(1)) >> 1;

  // write port
  logic              we;
  logic [AW-1:0]     wa;
  logic [EntryW-1:0] wd;
  logic              r_less;
  logic [CW:0]       s_idx;
  logic [EntryW-1:0] s_val;

  always_comb begin
    r_less = r_ok_q && (rd_b_q < rd_a_q);
    s_idx  = r_less ? r_w : l_w;
    s_val  = r_less ? rd_b_q : rd_a_q;
  end

  always_comb begin
    we = 1'b0; wa = '0; wd = v_q;
    case (state_q)
      S_IDLE: begin
        we = start_i;
        wa = insert_i ? AW'(count_i - CW'(1)) : '0;
        wd = val_i;
      end
      // hole reached the root: the held value lands there
      S_UP_RD: if (at_q == '0) begin
        we = 1'b1; wa = '0; wd = v_q;
      end
      S_UP_CMP: if (v_q < rd_a_q) begin
        we = 1'b1; wa = AW'(at_q); wd = rd_a_q;
      end else begin
        we = 1'b1; wa = AW'(at_q); wd = v_q;
      end
      // hole has no child: the held value lands there
      S_DN_RD: if (!(l_w < (CW+1)'(n_q))) begin
        we = 1'b1; wa = AW'(at_q); wd = v_q;
      end
      S_DN_CMP: if (s_val < v_q) begin
        we = 1'b1; wa = AW'(at_q); wd = s_val;
      end else begin
        we = 1'b1; wa = AW'(at_q); wd = v_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_a_q <= mem[(state_q == S_UP_RD) ? AW'(p_w) : AW'(l_w)];
    rd_b_q <= mem[AW'(r_w)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      at_q <= '0; n_q <= '0; v_q <= '0; r_ok_q <= 1'b0;
      root_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) begin
          v_q <= val_i;
          n_q <= count_i;
          if (insert_i) begin
            at_q <= (CW+1)'(count_i - CW'(1));
            state_q <= S_UP_RD;
          end else begin
            at_q <= '0;
            state_q <= S_DN_RD;
          end
        end
        S_UP_RD: state_q <= (at_q == '0) ? S_DONE : S_UP_CMP;
        S_UP_CMP: begin
          if (v_q < rd_a_q) begin
            at_q <= p_w;
            state_q <= S_UP_RD;
          end else state_q <= S_DONE;
        end
        S_DN_RD: begin
          r_ok_q <= r_w < (CW+1)'(n_q);
          state_q <= (l_w < (CW+1)'(n_q)) ? S_DN_WAIT : S_DONE;
        end
        S_DN_WAIT: state_q <= S_DN_CMP;
        S_DN_CMP: begin
          if (s_val < v_q) begin
            at_q <= s_idx;
            state_q <= S_DN_RD;
          end else state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (we && wa == '0) root_q <= wd;
    end
  end

  // S_UP_RD issues the parent read: rd_a_q valid in S_UP_CMP. S_DN_RD then
  // S_DN_WAIT captures child reads.
  assign done_o = (state_q == S_DONE);
  assign root_o = root_q;
endmodule

// ===== rtl/top_m_positive_sum_with_penalty_top.sv =====
`timescale 1ns / 1ps
// top-m positive running sum with per-position penalty
// input stream s_axis: value and last; output stream m_axis: best_so_far and last_out
// cfg channel writes max_kept (index 0) or penalty (index 1) while idle
// positive values go into a min-heap, which grows only while below max_kept
// with no heap update a word passes S_MUL0, S_MUL1, S_BEST and S_OUT
// before the next accept, its result showing on m_axis in S_OUT
// an insert or replace adds S_HEAP, which waits for the heap sequencer
// to finish its sift-up or sift-down walk
// the cost multiply is two 31x16 partial products, low one registered in S_MUL0
// one word in flight: s_axis_tready is low while an item is worked on
// or while its result waits in the output register
// reset clears stream state, max_kept to 1 and penalty to 0; heap memory
// needs no clearing, only entries below the count are read
// a stall on m_axis_tready holds the result and keeps s_axis_tready low
// last set clears the stream once its result is taken on m_axis
module top_m_positive_sum_with_penalty_top import tmpsp_pkg::*; #(
  parameter int unsigned HeapDepth = HeapDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // value[31:0]
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,   // best_so_far[38:0], zero pad
  output logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  localparam int unsigned CW = $clog2(HeapDepth+1);

  typedef enum logic [2:0] { S_IDLE, S_MUL0, S_MUL1, S_HEAP, S_BEST, S_OUT } state_e;

  state_e              state_q;
  logic [KeptW-1:0]    max_kept_q;
  logic [PenW-1:0]     penalty_q;
  logic [CW-1:0]       count_q;
  logic [SumW-1:0]     sum_q, best_q, cost_q;
  logic [PosW-1:0]     pos_q;
  logic [EntryW-1:0]   val_q, top_q;
  logic                pos_ok_q, last_q;
  logic                heap_start, heap_ins, heap_done;
  logic [EntryW-1:0]   heap_root;
  logic [CW-1:0]       cap, heap_cnt;
  logic [63:0]         cost_full;

  // root value shadow: heap minimum kept in a register so the replace test
  // needs no memory read
  assign cap = (32'(max_kept_q) > HeapDepth) ? CW'(HeapDepth)
             : CW'(max_kept_q);

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {1'b0, best_q};
  assign m_axis_tlast  = last_q;

  logic insert_c, replace_c;
  assign insert_c  = pos_ok_q && (count_q < cap);
  assign replace_c = pos_ok_q && !(count_q < cap) && (count_q != '0) && (val_q > top_q);
  assign heap_start = (state_q == S_MUL1) && (insert_c || replace_c);
  assign heap_ins   = insert_c;
  assign heap_cnt   = insert_c ? count_q + CW'(1) : count_q;

  tmpsp_heap #(.HeapDepth(HeapDepth)) u_heap (
    .clk_i, .rst_ni,
    .start_i(heap_start), .insert_i(heap_ins), .val_i(val_q),
    .count_i(heap_cnt), .done_o(heap_done), .root_o(heap_root)
  );

  // heap minimum tracking: insert gives min(top,val); after any heap
  // update the root copy from the heap is taken
  logic [63:0] prod_lo_q;
  logic [SumW-1:0] cand;
  assign cand = (sum_q > cost_q) ? sum_q - cost_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_kept_q <= KeptW'(1); penalty_q <= '0;
      count_q <= '0; sum_q <= '0; best_q <= '0; pos_q <= '0;
      cost_q <= '0; val_q <= '0; top_q <= '0; pos_ok_q <= 1'b0; last_q <= 1'b0;
      prod_lo_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              CfgMaxKept: max_kept_q <= cfg_data_i[KeptW-1:0];
              CfgPenalty: penalty_q  <= cfg_data_i[PenW-1:0];
              default: ;
            endcase
          end else if (s_axis_tvalid) begin
            val_q    <= s_axis_tdata[EntryW-1:0];
            pos_ok_q <= (s_axis_tdata != '0) && !s_axis_tdata[31];
            last_q   <= s_axis_tlast;
            if (pos_q != '1) pos_q <= pos_q + PosW'(1);
            state_q <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod_lo_q <= 64'(penalty_q) * 64'(pos_q[15:0]);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          cost_q <= (|cost_full[63:SumW]) ? '1 : cost_full[SumW-1:0];
          if (insert_c) begin
            count_q <= count_q + CW'(1);
            sum_q <= sum_q + SumW'(val_q);
            if (count_q == '0 || val_q < top_q) top_q <= val_q;
            state_q <= S_HEAP;
          end else if (replace_c) begin
            sum_q <= sum_q - SumW'(top_q) + SumW'(val_q);
            state_q <= S_HEAP;
          end else state_q <= S_BEST;
        end
        S_HEAP: if (heap_done) begin
          top_q <= heap_root;
          state_q <= S_BEST;
        end
        S_BEST: begin
          if (cand > best_q) best_q <= cand;
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          if (last_q) begin
            count_q <= '0; sum_q <= '0; best_q <= '0; pos_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // second partial product; sum kept small enough since cost saturates
  logic [63:0] prod_hi;
  assign prod_hi   = 64'(penalty_q) * 64'(pos_q[31:16]);
  assign cost_full = prod_lo_q + (prod_hi << 16);
endmodule

// ===== sim/top_m_positive_sum_with_penalty_checker.sv =====
`timescale 1ns / 1ps
module top_m_positive_sum_with_penalty_checker import tmpsp_pkg::*; #(
  parameter int unsigned HeapDepth = HeapDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [39:0]        m_axis_tdata,
  input  logic               m_axis_tlast,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic [SumW-1:0] best;
    logic            last;
  } best_word_t;

  best_word_t          best_q[$];
  logic [EntryW-1:0]   heap[HeapDepth];
  int unsigned         heap_n;
  logic [63:0]         kept_sum;
  logic [63:0]         best_val;
  logic [PosW-1:0]     pos;
  logic [KeptW-1:0]    kept_max;
  logic [PenW-1:0]     pen;

  function automatic void stream_clear();
    heap_n   = 0;
    kept_sum = '0;
    best_val = '0;
    pos      = '0;
  endfunction

  function automatic void sift_down_root();
    int unsigned n, at, l, r, s;
    logic [EntryW-1:0] t;
    n  = (heap_n > HeapDepth) ? HeapDepth : heap_n;
    at = 0;
    while (2 * at + 1 < n) begin
      l = 2 * at + 1;
      r = l + 1;
      s = l;
      if (r < n && heap[r] < heap[s]) s = r;
      if (heap[at] <= heap[s]) break;
      t = heap[at]; heap[at] = heap[s]; heap[s] = t;
      at = s;
    end
  endfunction

  // one input word through the top-m heap, returns the expected result
  function automatic best_word_t absorb_value(logic [31:0] raw, logic lst);
    int unsigned cap, at, par;
    logic        positive;
    logic [63:0] cost, cand;
    logic [EntryW-1:0] t;
    best_word_t  res;
    positive = (raw != 0) && !raw[31];
    cap = (kept_max > HeapDepth) ? HeapDepth : kept_max;
    if (pos != '1) pos = pos + 1;
    if (heap_n < cap) begin
      if (positive) begin
        heap[heap_n] = raw[30:0];
        at = heap_n;
        while (at > 0) begin
          par = (at - 1) / 2;
          if (!(heap[at] < heap[par])) break;
          t = heap[at]; heap[at] = heap[par]; heap[par] = t;
          at = par;
        end
        heap_n++;
        kept_sum += {32'd0, raw};
      end
    end else if (heap_n > 0) begin
      // full heap: replace the minimum if the new value beats it
      if (positive && raw[30:0] > heap[0]) begin
        kept_sum = kept_sum - {33'd0, heap[0]} + {32'd0, raw};
        heap[0] = raw[30:0];
        sift_down_root();
      end
    end
    cost = {33'd0, pen} * {32'd0, pos};
    if (kept_sum > cost) begin
      cand = kept_sum - cost;
      if (cand > 64'h7F_FFFF_FFFF) cand = 64'h7F_FFFF_FFFF;
      if (cand > best_val) best_val = cand;
    end
    res.best = best_val[SumW-1:0];
    res.last = lst;
    if (lst) stream_clear();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    best_word_t want;
    if (!rst_ni) begin
      best_q.delete();
      stream_clear();
      kept_max     = 9'd1;
      pen          = '0;
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgMaxKept: kept_max = cfg_data_i[KeptW-1:0];
          CfgPenalty: pen      = cfg_data_i[PenW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        best_q.push_back(absorb_value(s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o++;
        if (best_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result word: best %0d last %0b",
                     m_axis_tdata[SumW-1:0], m_axis_tlast);
        end else begin
          want = best_q.pop_front();
          if (m_axis_tdata !== {1'b0, want.best} || m_axis_tlast !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected best %0d last %0b, got tdata %0h last %0b",
                       want.best, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      pending_o = best_q.size();
    end
  end

endmodule

// ===== sim/top_m_positive_sum_with_penalty_top_test.sv =====
`timescale 1ns / 1ps
module top_m_positive_sum_with_penalty_top_test;
  import tmpsp_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;   // value[31:0]
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [39:0]        m_axis_tdata;        // best_so_far[38:0], zero pad
  logic               m_axis_tlast;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgMaxKept;
  logic [31:0]        cfg_data_i = '0;

  int fail_count, pending, checked;
  int sent_items;
  int stall_left;
  int idle_cycles = 0;
  bit quiet;

  always #1 clk_i = ~clk_i;

  top_m_positive_sum_with_penalty_top dut (.*);

  top_m_positive_sum_with_penalty_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // receiver back-pressure in random bursts, none once quiet
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [31:0] value, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // register write only once the block has drained
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == CfgMaxKept) ? 32'h1FF : 32'h7FFF_FFFF;
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    // junk above the register width must be ignored
    cfg_data_i  <= (val & mask) | ($urandom & ~mask);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return $urandom_range(1, 1000);
      5, 6, 7: return $urandom & 32'h7FFF_FFFF;
      8:       return $urandom;
      default: return -$urandom_range(1, 1000);
    endcase
  endfunction

  task automatic send_stream(int len);
    for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
  endtask

  int unsigned kept_set[8] = '{0, 1, 3, 256, 300, 511, 2, 16};
  int unsigned pen_set[8]  = '{0, 32'h7FFF_FFFF, 7, 1000, 0, 12345, 0, 0};

  initial begin
    int budget;
    quiet = 1'b0;
    sent_items = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: default settings, edge values, non-positive values, stream ends
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'd1, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'd5, 1'b1);
    write_reg(CfgMaxKept, 32'd4);
    write_reg(CfgPenalty, 32'd2);
    for (int i = 0; i < 8; i++) send_word(32'd10 * (8 - i), 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'd3, 1'b1);
    // capacity lowered while a stream is open
    write_reg(CfgMaxKept, 32'd8);
    for (int i = 0; i < 8; i++) send_word(32'd100 + i, 1'b0);
    write_reg(CfgMaxKept, 32'd3);
    send_word(32'd500, 1'b0);
    send_word(32'd50, 1'b0);
    send_word(32'd600, 1'b1);

    // random phases over capacity and penalty settings
    for (int p = 0; p < 8; p++) begin
      write_reg(CfgMaxKept, kept_set[p]);
      write_reg(CfgPenalty, p == 7 ? ($urandom & 32'h7FFF) : pen_set[p]);
      if (p == 3) begin
        // fill a full-depth heap and keep replacing its minimum
        for (int i = 0; i < 300; i++)
          send_word($urandom & 32'h7FFF_FFFF, i == 299);
      end
      if (p == 7) quiet = 1'b1;
      budget = 65;
      while (budget > 0) begin
        if (p == 2) begin
          @(negedge clk_i) s_axis_tvalid <= 1'b0;
          wait (pending == 0);
        end
        send_stream($urandom_range(1, 30));
        budget -= 15;
      end
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    $display("sent %0d words, checked %0d results across 8 capacity/penalty settings",
             sent_items, checked);
    $display("covered empty and full-depth heaps, capacity cut mid-stream, back-pressure");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
